// ----- design/bcmb_pkg.sv -----
package bcmb_pkg;

    // Width of the running memory address
    localparam int ADDR_BITS = 16;

    // Host command letters
    localparam logic [7:0] CMD_READ      = 8'h72;  // 'r'
    localparam logic [7:0] CMD_WRITE     = 8'h77;  // 'w'
    localparam logic [7:0] CMD_MODIFY    = 8'h6D;  // 'm'
    localparam logic [7:0] CMD_NEXT_READ = 8'h6E;  // 'n'

    // ASCII bases for hex digits
    localparam logic [7:0] ASCII_ZERO   = 8'h30;   // '0'
    localparam logic [7:0] ASCII_ALPHA  = 8'h37;   // 'A' - 10
    localparam logic [3:0] DECIMAL_TOP  = 4'd9;

    // Source of an input request
    typedef enum logic {
        OP_HOST = 1'b0,
        OP_MEM  = 1'b1
    } op_t;

    // Kind of a result
    typedef enum logic [1:0] {
        KIND_WRITE = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CHAR  = 2'd2
    } kind_t;

    // Command waiting for its arguments
    typedef enum logic [1:0] {
        PEND_NONE   = 2'd0,
        PEND_READ   = 2'd1,
        PEND_WRITE  = 2'd2,
        PEND_MODIFY = 2'd3
    } pend_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] value;
    } cmd_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] mem_address;
        logic [7:0]  mem_data;
        logic [7:0]  host_char;
        logic        last;
    } rsp_item_t;

    typedef struct packed {
        logic [ADDR_BITS-1:0] address;
        pend_t                pend;
        logic [1:0]           argc;
    } bcmb_state_t;

    // Results of one decoded request: up to two
    typedef struct packed {
        logic [1:0] count;
        rsp_item_t  first;
        rsp_item_t  second;
    } bcmb_result_t;

    // Map a nibble to an upper-case ASCII hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] nibble);
        logic [7:0] base;
        base = (nibble > DECIMAL_TOP) ? ASCII_ALPHA : ASCII_ZERO;
        return base + {4'h0, nibble};
    endfunction

endpackage

// ----- design/bcmb_decode.sv -----
module bcmb_decode
    import bcmb_pkg::*;
(
    input  cmd_item_t    item,
    input  bcmb_state_t  state,
    output bcmb_state_t  state_next,
    output bcmb_result_t result
);

    logic [ADDR_BITS-1:0] addr_inc;
    logic [ADDR_BITS-1:0] addr_high;
    logic [ADDR_BITS-1:0] addr_add;
    rsp_item_t            blank;

    assign addr_inc  = state.address + ADDR_BITS'(1);
    assign addr_high = ADDR_BITS'({item.value, 8'h00});
    assign addr_add  = state.address + ADDR_BITS'(item.value);

    // Decode one request against the command state
    always_comb
    begin
        blank              = '0;
        blank.last         = 1'b1;
        state_next         = state;
        result.count       = 2'd0;
        result.first       = blank;
        result.second      = blank;

        if (item.op == OP_MEM)
        begin
            // Read data goes back as two hex characters, high nibble first
            result.count            = 2'd2;
            result.first.kind       = KIND_CHAR;
            result.first.host_char  = hex_char(item.value[7:4]);
            result.first.last       = 1'b0;
            result.second.kind      = KIND_CHAR;
            result.second.host_char = hex_char(item.value[3:0]);
        end
        else
        begin
            case (state.pend)
                PEND_NONE:
                begin
                    if (item.value == CMD_READ)
                    begin
                        state_next.pend = PEND_READ;
                        state_next.argc = 2'd0;
                    end
                    else if (item.value == CMD_WRITE)
                    begin
                        state_next.pend = PEND_WRITE;
                        state_next.argc = 2'd0;
                    end
                    else if (item.value == CMD_MODIFY)
                    begin
                        state_next.pend = PEND_MODIFY;
                        state_next.argc = 2'd0;
                    end
                    else if (item.value == CMD_NEXT_READ)
                    begin
                        state_next.address       = addr_inc;
                        result.count             = 2'd1;
                        result.first.kind        = KIND_READ;
                        result.first.mem_address = 16'(addr_inc);
                    end
                end
                PEND_MODIFY:
                begin
                    state_next.address       = addr_inc;
                    state_next.pend          = PEND_NONE;
                    state_next.argc          = 2'd0;
                    result.count             = 2'd1;
                    result.first.kind        = KIND_WRITE;
                    result.first.mem_address = 16'(addr_inc);
                    result.first.mem_data    = item.value;
                end
                PEND_READ:
                begin
                    if (state.argc == 2'd0)
                    begin
                        state_next.address = addr_high;
                        state_next.argc    = 2'd1;
                    end
                    else
                    begin
                        state_next.address       = addr_add;
                        state_next.pend          = PEND_NONE;
                        state_next.argc          = 2'd0;
                        result.count             = 2'd1;
                        result.first.kind        = KIND_READ;
                        result.first.mem_address = 16'(addr_add);
                    end
                end
                default:
                begin
                    // Write: high byte, low byte, then data
                    if (state.argc == 2'd0)
                    begin
                        state_next.address = addr_high;
                        state_next.argc    = 2'd1;
                    end
                    else if (state.argc == 2'd1)
                    begin
                        state_next.address = addr_add;
                        state_next.argc    = 2'd2;
                    end
                    else
                    begin
                        state_next.pend          = PEND_NONE;
                        state_next.argc          = 2'd0;
                        result.count             = 2'd1;
                        result.first.kind        = KIND_WRITE;
                        result.first.mem_address = 16'(state.address);
                        result.first.mem_data    = item.value;
                    end
                end
            endcase
        end
    end

endmodule

// ----- design/byte_command_memory_bridge.sv -----
// Byte command bridge: host bytes ('r' hi lo, 'w' hi lo data, 'm' data, 'n')
// become memory read and write requests, and returned read bytes become two
// upper-case hex characters for the host. While the host takes results, a host
// byte can follow the previous one in the next cycle and the two characters of
// a read-data byte leave one per cycle through the output register and a
// one-entry hold slot; no new request is taken while the hold slot is full.
// The command state updates in the cycle a request is accepted.
module byte_command_memory_bridge
    import bcmb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    output logic      cmd_ready,
    input  cmd_item_t cmd,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_item_t rsp
);

    bcmb_state_t  state_reg;
    bcmb_state_t  state_next;
    bcmb_result_t dec;
    logic         rsp_valid_reg;
    logic         rsp_valid_next;
    rsp_item_t    rsp_reg;
    rsp_item_t    rsp_next;
    logic         hold_valid_reg;
    logic         hold_valid_next;
    rsp_item_t    hold_reg;
    rsp_item_t    hold_next;
    logic         cmd_fire;
    logic         rsp_fire;

    bcmb_decode u_decode (
        .item       (cmd),
        .state      (state_reg),
        .state_next (state_next),
        .result     (dec)
    );

    assign cmd_ready = !hold_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign cmd_fire  = cmd_valid && cmd_ready;
    assign rsp_fire  = rsp_valid_reg && rsp_ready;
    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // Steer new results into the output register and hold slot
    always_comb
    begin
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_next        = rsp_reg;
        hold_valid_next = hold_valid_reg;
        hold_next       = hold_reg;
        if (cmd_fire)
        begin
            rsp_valid_next  = (dec.count != 2'd0);
            rsp_next        = dec.first;
            hold_valid_next = (dec.count == 2'd2);
            hold_next       = dec.second;
        end
        else if (rsp_fire && hold_valid_reg)
        begin
            rsp_valid_next  = 1'b1;
            rsp_next        = hold_reg;
            hold_valid_next = 1'b0;
        end
    end

    // Control and command state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= '{address: '0, pend: PEND_NONE, argc: 2'd0};
            rsp_valid_reg  <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd_fire)
            begin
                state_reg <= state_next;
            end
            rsp_valid_reg  <= rsp_valid_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        rsp_reg  <= rsp_next;
        hold_reg <= hold_next;
    end

    // A waiting second character always sits behind a shown first one
    a_hold_behind_rsp: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> rsp_valid_reg)
        else $error("hold slot full with output register empty");

    // Only a final result ever waits in the hold slot
    a_hold_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> hold_reg.last)
        else $error("non-final result in hold slot");

    // A non-final result always has its sibling queued
    a_not_last_has_sibling: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid_reg && !rsp_reg.last |-> hold_valid_reg)
        else $error("non-final result without queued sibling");

    // Read data yields a first hex character with its second queued
    a_mem_two_chars: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_fire && cmd.op == OP_MEM |=>
            rsp_valid_reg && rsp_reg.kind == KIND_CHAR && !rsp_reg.last
            && hold_valid_reg && hold_reg.kind == KIND_CHAR)
        else $error("read data did not produce two characters");

    // No arguments are counted while idle
    a_idle_no_args: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg.pend == PEND_NONE |-> state_reg.argc == 2'd0)
        else $error("argument count set with no command pending");

endmodule
